>>> rtl/isort_pkg.sv
package isort_pkg;

  localparam int unsigned MaxItems = 64;
  localparam int unsigned IdxW     = $clog2(MaxItems);
  localparam int unsigned CntW     = $clog2(MaxItems + 1);
  localparam int unsigned DataW    = 32;
  localparam int unsigned CmpW     = 13;
  localparam int unsigned MovW     = 12;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned OutPackW = DataW + CmpW + MovW;
  localparam int unsigned OutDataW = ((OutPackW + 7) / 8) * 8;

  typedef enum logic [ModeW-1:0] {
    ORDER_ASC      = 2'd0,
    ORDER_EVEN_ODD = 2'd1,
    ORDER_DESC     = 2'd2
  } order_mode_e;

  // controller to datapath
  typedef struct packed {
    logic in_load;      // latch the incoming item
    logic drop;         // store full, flag the loss
    logic first_write;  // first element goes straight to slot 0
    logic start_shift;  // open an insertion, read the top entry
    logic cmp_step;     // one compare-and-shift pass
    logic place;        // write the new element at slot 0
    logic emit_rd;      // read the entry to emit
    logic emit_ld;      // move read data into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic goes_before;
    logic j_is_one;
    logic last;
    logic out_free;
    logic emit_final;
  } stat_t;

  // true when new value x moves past stored value y
  function automatic logic goes_before(input logic signed [DataW-1:0] x,
                                       input logic signed [DataW-1:0] y,
                                       input logic [ModeW-1:0] mode);
    logic res;
    case (mode)
      ORDER_EVEN_ODD: res = !x[0] && y[0] && !y[DataW-1];
      ORDER_DESC:     res = x > y;
      default:        res = y > x;
    endcase
    return res;
  endfunction

endpackage

>>> rtl/isort_dp.sv
module isort_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  isort_pkg::cmd_t                     cmd_i,
  output isort_pkg::stat_t                    stat_o,
  input  logic [isort_pkg::ModeW-1:0]         mode_i,
  input  logic signed [isort_pkg::DataW-1:0]  in_value_i,
  input  logic                                in_last_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic signed [isort_pkg::DataW-1:0]  out_value_o,
  output logic                                out_last_o,
  output logic [isort_pkg::CmpW-1:0]          out_cmp_o,
  output logic [isort_pkg::MovW-1:0]          out_mov_o,
  output logic                                out_drop_o
);

  logic signed [isort_pkg::DataW-1:0] mem [isort_pkg::MaxItems];

  logic signed [isort_pkg::DataW-1:0] x_q, rdata_q;
  logic                               last_q;
  logic [isort_pkg::CntW-1:0]         cnt_q, cnt_d;
  logic [isort_pkg::IdxW-1:0]         j_q, j_d;
  logic [isort_pkg::IdxW-1:0]         k_q, k_d;
  logic [isort_pkg::CmpW-1:0]         cmp_q, cmp_d;
  logic [isort_pkg::MovW-1:0]         mov_q, mov_d;
  logic                               drop_q, drop_d;
  logic                               out_valid_q, out_valid_d;
  logic signed [isort_pkg::DataW-1:0] out_value_q;
  logic                               out_last_q;
  logic [isort_pkg::CmpW-1:0]         out_cmp_q;
  logic [isort_pkg::MovW-1:0]         out_mov_q;
  logic                               out_drop_q;

  logic                               gb;
  logic                               emit_final;
  logic                               we;
  logic [isort_pkg::IdxW-1:0]         waddr, raddr;
  logic signed [isort_pkg::DataW-1:0] wdata;

  assign gb         = isort_pkg::goes_before(x_q, rdata_q, mode_i);
  assign emit_final = (isort_pkg::CntW'(k_q) + 1'b1) == cnt_q;

  // memory port control
  always_comb begin
    we    = 1'b0;
    waddr = j_q;
    wdata = x_q;
    raddr = '0;
    if (cmd_i.first_write) begin
      we    = 1'b1;
      waddr = '0;
    end
    if (cmd_i.start_shift) begin
      raddr = isort_pkg::IdxW'(cnt_q - 1'b1);
    end
    if (cmd_i.cmp_step) begin
      we    = 1'b1;
      raddr = j_q - isort_pkg::IdxW'(2);
      if (gb) begin
        wdata = rdata_q;
      end
    end
    if (cmd_i.place) begin
      we = 1'b1;
    end
    if (cmd_i.emit_rd) begin
      raddr = k_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // counters and tallies
  always_comb begin
    cnt_d       = cnt_q;
    j_d         = j_q;
    k_d         = k_q;
    cmp_d       = cmp_q;
    mov_d       = mov_q;
    drop_d      = drop_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.drop) begin
      drop_d = 1'b1;
    end
    if (cmd_i.first_write) begin
      cnt_d = isort_pkg::CntW'(1);
    end
    if (cmd_i.start_shift) begin
      cmp_d = cmp_q + isort_pkg::CmpW'(1);
      j_d   = isort_pkg::IdxW'(cnt_q);
    end
    if (cmd_i.cmp_step) begin
      cmp_d = cmp_q + isort_pkg::CmpW'(3);
      mov_d = mov_q + isort_pkg::MovW'(1);
      if (gb) begin
        j_d = j_q - isort_pkg::IdxW'(1);
      end else begin
        cnt_d = cnt_q + isort_pkg::CntW'(1);
      end
    end
    if (cmd_i.place) begin
      mov_d = mov_q + isort_pkg::MovW'(1);
      cnt_d = cnt_q + isort_pkg::CntW'(1);
    end
    if (cmd_i.emit_ld) begin
      out_valid_d = 1'b1;
      if (emit_final) begin
        // array done: clear for the next one
        cnt_d  = '0;
        k_d    = '0;
        cmp_d  = '0;
        mov_d  = '0;
        drop_d = 1'b0;
      end else begin
        k_d = k_q + isort_pkg::IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      j_q         <= '0;
      k_q         <= '0;
      cmp_q       <= '0;
      mov_q       <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      j_q         <= j_d;
      k_q         <= k_d;
      cmp_q       <= cmp_d;
      mov_q       <= mov_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      x_q    <= in_value_i;
      last_q <= in_last_i;
    end
    if (cmd_i.emit_ld) begin
      out_value_q <= rdata_q;
      out_last_q  <= emit_final;
      out_cmp_q   <= cmp_q;
      out_mov_q   <= mov_q;
      out_drop_q  <= drop_q;
    end
  end

  assign stat_o.full        = cnt_q == isort_pkg::CntW'(isort_pkg::MaxItems);
  assign stat_o.empty       = cnt_q == '0;
  assign stat_o.goes_before = gb;
  assign stat_o.j_is_one    = j_q == isort_pkg::IdxW'(1);
  assign stat_o.last        = last_q;
  assign stat_o.out_free    = !out_valid_q || out_ready_i;
  assign stat_o.emit_final  = emit_final;

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;
  assign out_cmp_o   = out_cmp_q;
  assign out_mov_o   = out_mov_q;
  assign out_drop_o  = out_drop_q;

endmodule

>>> rtl/isort_ctrl.sv
module isort_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  isort_pkg::stat_t  stat_i,
  output isort_pkg::cmd_t   cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_START = 6'b000010,
    S_CMP   = 6'b000100,
    S_PLACE = 6'b001000,
    S_EM_RD = 6'b010000,
    S_EM_LD = 6'b100000
  } state_e;

  state_e state_q, state_d, after_ins;

  // where to go once an element is stored or dropped
  assign after_ins = stat_i.last ? S_EM_RD : S_IDLE;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          state_d       = S_START;
        end
      end
      S_START: begin
        if (stat_i.full) begin
          cmd_o.drop = 1'b1;
          state_d    = after_ins;
        end else if (stat_i.empty) begin
          cmd_o.first_write = 1'b1;
          state_d           = after_ins;
        end else begin
          cmd_o.start_shift = 1'b1;
          state_d           = S_CMP;
        end
      end
      S_CMP: begin
        cmd_o.cmp_step = 1'b1;
        if (stat_i.goes_before) begin
          state_d = stat_i.j_is_one ? S_PLACE : S_CMP;
        end else begin
          state_d = after_ins;
        end
      end
      S_PLACE: begin
        cmd_o.place = 1'b1;
        state_d     = after_ins;
      end
      S_EM_RD: begin
        cmd_o.emit_rd = 1'b1;
        state_d       = S_EM_LD;
      end
      S_EM_LD: begin
        cmd_o.emit_rd = 1'b1;
        if (stat_i.out_free) begin
          cmd_o.emit_ld = 1'b1;
          state_d       = stat_i.emit_final ? S_IDLE : S_EM_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = state_q == S_IDLE;

endmodule

>>> rtl/insertion_sorter.sv
// insertion: an element that is the first of its array, or is dropped, is written or
//   flagged straight from the start state; otherwise the start state reads the top
//   entry, then one compare-and-shift pass of the single-port store runs per cycle
// emission: each sorted item takes a store read, then the output register load, plus stalls
// throughput: one element at a time; the final sorted item may wait while the next starts
// reset: async active low, clears control, counts, flags and order_mode; store is not cleared
module insertion_sorter (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // config: order_mode
  input  logic                                  cfg_we_i,
  input  logic [isort_pkg::ModeW-1:0]           cfg_wdata_i,
  // input stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [isort_pkg::DataW-1:0]           s_axis_tdata,  // [31:0] element_value
  input  logic                                  s_axis_tlast,  // is_last
  // output stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [31:0] sorted_value, [44:32] comparison_count, [56:45] move_count, [63:57] zero
  output logic [isort_pkg::OutDataW-1:0]        m_axis_tdata,
  output logic                                  m_axis_tlast,  // last_out
  output logic                                  m_axis_tuser   // overflow
);

  isort_pkg::cmd_t  cmd;
  isort_pkg::stat_t stat;

  logic [isort_pkg::ModeW-1:0]        mode_q;
  logic signed [isort_pkg::DataW-1:0] out_value;
  logic [isort_pkg::CmpW-1:0]         out_cmp;
  logic [isort_pkg::MovW-1:0]         out_mov;

  // order mode register, the host must write it only while no item is in flight; the block does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= isort_pkg::ORDER_ASC;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  isort_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  isort_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .mode_i      (mode_q),
    .in_value_i  (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_value_o (out_value),
    .out_last_o  (m_axis_tlast),
    .out_cmp_o   (out_cmp),
    .out_mov_o   (out_mov),
    .out_drop_o  (m_axis_tuser)
  );

  // pack result fields, lowest first, zero padded to whole bytes
  assign m_axis_tdata = isort_pkg::OutDataW'({out_mov, out_cmp, out_value});

endmodule

>>> rtl/isort_checker.sv
module isort_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [isort_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                           m_axis_tlast,
  input logic                           m_axis_tuser
);

  // stalled result keeps its valid
  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // stalled result keeps its payload
  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // s_axis_tready is low right after an accepted element, so none are accepted back to back
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("element accepted back to back");

  // padding bits above the packed fields stay zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[isort_pkg::OutDataW-1:isort_pkg::OutPackW] == '0)
    else $error("nonzero padding in result");

endmodule

bind insertion_sorter isort_checker u_isort_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
